// ===== hdl/tk_pkg.sv =====
// shared types and codes for the three-axis tracker
package tk_pkg;

    // command codes of an input item
    typedef enum logic [1:0] {
        OP_PREDICT = 2'd0,
        OP_MEASURE = 2'd1,
        OP_PROJECT = 2'd2,
        OP_LOAD    = 2'd3
    } tk_op_t;

    // configuration register indexes
    localparam logic [1:0] CFG_Q_VAR     = 2'd0;
    localparam logic [1:0] CFG_R_VAR     = 2'd1;
    localparam logic [1:0] CFG_TIME_STEP = 2'd2;

    // multiplier operand selection
    typedef enum logic [1:0] {
        MUL_PRED = 2'd0,
        MUL_PROJ = 2'd1,
        MUL_POS  = 2'd2,
        MUL_VAR  = 2'd3
    } tk_mul_sel_t;

    // controller to lane commands
    typedef struct packed {
        logic        capture;
        tk_mul_sel_t mul_sel;
        logic        div_gain_start;
        logic        div_vel_start;
        logic        wr_load;
        logic        wr_pred;
        logic        wr_proj;
        logic        wr_k;
        logic        wr_npos;
        logic        wr_meas;
        logic        load_out;
        logic        out_proj;
    } tk_cmd_t;

    // lane to controller status
    typedef struct packed {
        logic div_busy;
    } tk_status_t;

endpackage

// ===== hdl/tk_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module tk_div #(
    parameter int DW = 49
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [DW-1:0]              dividend,
    input  logic [32:0]                divisor,
    input  logic [32:0]                rem_init,
    input  logic [$clog2(DW+1)-1:0]    steps,
    output logic                       busy,
    output logic [DW-1:0]              quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [32:0]   rem_reg, rem_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [32:0]   div_reg, div_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [33:0]   shifted;
    logic [33:0]   diff;
    logic          ge;

    // load on start, otherwise one restoring step
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        ge       = shifted >= {1'b0, div_reg};
        diff     = shifted - {1'b0, div_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        div_next = div_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = rem_init;
            quo_next = dividend;
            div_next = divisor;
            cnt_next = steps;
        end
        else if (cnt_reg != '0)
        begin
            rem_next = ge ? diff[32:0] : shifted[32:0];
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - CW'(1);
        end
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

// ===== hdl/tk_lane.sv =====
// one axis of the tracker: state, multiplier, divider and result registers
module tk_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tk_pkg::tk_cmd_t     cmd,
    input  logic signed [31:0]  value_in,
    input  logic signed [31:0]  load_vel_in,
    input  logic signed [31:0]  ahead_in,
    input  logic [30:0]         q_var,
    input  logic [30:0]         r_var,
    input  logic [30:0]         step_len,
    output tk_pkg::tk_status_t  status,
    output logic signed [31:0]  out_pos,
    output logic signed [31:0]  out_vel
);

    localparam int DW = 33 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);
    localparam logic [65:0]        HALF  = 66'(1) << (FRAC_BITS - 1);
    localparam logic [31:0]        ONE32 = 32'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0] K_ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [DW-1:0]      VMAX  = DW'(32'h7FFF_FFFF);
    localparam logic [DW-1:0]      VMIN  = DW'(33'h0_8000_0000);

    // saturate a wide signed value to 32 bits
    function automatic logic [31:0] sat32(input logic [65:0] v);
        logic [31:0] r;
        r = v[31:0];
        if (!v[65] && (|v[64:31]))
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v[65] && !(&v[64:31]))
        begin
            r = 32'h8000_0000;
        end
        return r;
    endfunction

    logic [31:0]        pos_reg, pos_next;
    logic [31:0]        vel_reg, vel_next;
    logic [31:0]        var_reg, var_next;
    logic [31:0]        val_reg, lvel_reg, ahead_reg;
    logic [FRAC_BITS:0] k_reg;
    logic [31:0]        npos_reg;
    logic [31:0]        proj_reg;
    logic [65:0]        prod_reg;
    logic [31:0]        opos_reg, ovel_reg;

    logic signed [32:0] mul_a, mul_b;
    logic [65:0]        prod_next;
    logic [65:0]        rnd;
    logic [31:0]        pos_sat;
    logic [32:0]        pvar;
    logic [31:0]        pvar_sat;
    logic [32:0]        den;
    logic [32:0]        diff2;
    logic [32:0]        mag;
    logic [DW-1:0]      quo;
    logic [31:0]        vel_sat;
    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic [32:0]        div_divisor;
    logic [32:0]        div_rem;
    logic [CW-1:0]      div_steps;
    logic               div_busy;

    // multiplier operand selection
    always_comb
    begin
        unique case (cmd.mul_sel)
            tk_pkg::MUL_PRED:
            begin
                mul_a = {vel_reg[31], vel_reg};
                mul_b = {2'b00, step_len};
            end
            tk_pkg::MUL_PROJ:
            begin
                mul_a = {vel_reg[31], vel_reg};
                mul_b = {ahead_reg[31], ahead_reg};
            end
            tk_pkg::MUL_POS:
            begin
                mul_a = {val_reg[31], val_reg} - {pos_reg[31], pos_reg};
                mul_b = {{(32 - FRAC_BITS){1'b0}}, k_reg};
            end
            tk_pkg::MUL_VAR:
            begin
                mul_a = {1'b0, var_reg};
                mul_b = {{(32 - FRAC_BITS){1'b0}}, K_ONE - k_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = 66'(mul_a * mul_b);
    end

    // rounding rescale, position sum, variance sums and position difference
    always_comb
    begin
        rnd      = 66'($signed(prod_reg + HALF) >>> FRAC_BITS);
        pos_sat  = sat32({{34{pos_reg[31]}}, pos_reg} + rnd);
        pvar     = {1'b0, var_reg} + {2'b00, q_var};
        pvar_sat = pvar[32] ? 32'hFFFF_FFFF : pvar[31:0];
        den      = {1'b0, var_reg} + {2'b00, r_var};
        diff2    = {npos_reg[31], npos_reg} - {pos_reg[31], pos_reg};
        mag      = diff2[32] ? (33'd0 - diff2) : diff2;
    end

    // velocity from the quotient, truncated toward zero and saturated
    always_comb
    begin
        if (diff2[32])
        begin
            vel_sat = (quo > VMIN) ? 32'h8000_0000 : 32'(VMIN - quo + VMIN);
            if (quo <= VMIN)
            begin
                vel_sat = 32'(~quo + DW'(1));
            end
        end
        else
        begin
            vel_sat = (quo > VMAX) ? 32'h7FFF_FFFF : quo[31:0];
        end
    end

    // divider setup for gain or velocity
    always_comb
    begin
        div_start = cmd.div_gain_start | cmd.div_vel_start;
        if (cmd.div_gain_start)
        begin
            div_dividend = {var_reg[0], {(DW - 1){1'b0}}};
            div_divisor  = den;
            div_rem      = {2'b00, var_reg[31:1]};
            div_steps    = CW'(FRAC_BITS + 1);
        end
        else
        begin
            div_dividend = {mag, {FRAC_BITS{1'b0}}};
            div_divisor  = {2'b00, step_len};
            div_rem      = '0;
            div_steps    = CW'(DW);
        end
    end

    tk_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rem_init (div_rem),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (quo)
    );

    // next filter state
    always_comb
    begin
        pos_next = pos_reg;
        vel_next = vel_reg;
        var_next = var_reg;
        if (cmd.wr_load)
        begin
            pos_next = val_reg;
            vel_next = lvel_reg;
            var_next = ONE32;
        end
        else if (cmd.wr_pred)
        begin
            pos_next = pos_sat;
            var_next = pvar_sat;
        end
        else if (cmd.wr_meas)
        begin
            pos_next = npos_reg;
            vel_next = vel_sat;
            var_next = rnd[31:0];
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            vel_reg <= '0;
            var_reg <= ONE32;
        end
        else
        begin
            pos_reg <= pos_next;
            vel_reg <= vel_next;
            var_reg <= var_next;
        end
    end

    // operand, intermediate and result registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.capture)
        begin
            val_reg   <= value_in;
            lvel_reg  <= load_vel_in;
            ahead_reg <= ahead_in;
        end
        if (cmd.wr_k)
        begin
            k_reg <= (den == '0) ? '0 : quo[FRAC_BITS:0];
        end
        if (cmd.wr_npos)
        begin
            npos_reg <= pos_sat;
        end
        if (cmd.wr_proj)
        begin
            proj_reg <= pos_sat;
        end
        if (cmd.load_out)
        begin
            opos_reg <= cmd.out_proj ? proj_reg : pos_reg;
            ovel_reg <= vel_reg;
        end
    end

    assign status.div_busy = div_busy;
    assign out_pos         = opos_reg;
    assign out_vel         = ovel_reg;

endmodule

// ===== hdl/tk_ctrl.sv =====
// sequencing state machine and output handshake
module tk_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    output logic               out_valid,
    input  logic               out_ready,
    input  tk_pkg::tk_status_t status,
    output tk_pkg::tk_cmd_t    cmd
);

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_LOAD    = 14'b00000000000010,
        S_PMUL    = 14'b00000000000100,
        S_PWR     = 14'b00000000001000,
        S_JMUL    = 14'b00000000010000,
        S_JWR     = 14'b00000000100000,
        S_MSTART  = 14'b00000001000000,
        S_MGAIN   = 14'b00000010000000,
        S_MPMUL   = 14'b00000100000000,
        S_MNPOS   = 14'b00001000000000,
        S_MVSTART = 14'b00010000000000,
        S_MVWAIT  = 14'b00100000000000,
        S_MWR     = 14'b01000000000000,
        S_FINISH  = 14'b10000000000000
    } tk_state_t;

    tk_state_t state_reg, state_next;
    logic      oproj_reg, oproj_next;
    logic      ovalid_reg, ovalid_next;
    logic      accept;
    logic      can_load;

    assign in_ready = state_reg == S_IDLE;
    assign accept   = in_valid && in_ready;
    assign can_load = !ovalid_reg || out_ready;

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        oproj_next  = oproj_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        cmd.mul_sel = tk_pkg::MUL_VAR;
        cmd.out_proj = oproj_reg;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    oproj_next  = tk_pkg::tk_op_t'(command) == tk_pkg::OP_PROJECT;
                    unique case (tk_pkg::tk_op_t'(command))
                        tk_pkg::OP_PREDICT: state_next = S_PMUL;
                        tk_pkg::OP_MEASURE: state_next = S_MSTART;
                        tk_pkg::OP_PROJECT: state_next = S_JMUL;
                        tk_pkg::OP_LOAD:    state_next = S_LOAD;
                        default:            state_next = S_LOAD;
                    endcase
                end
            end
            S_LOAD:
            begin
                cmd.wr_load = 1'b1;
                state_next  = S_FINISH;
            end
            S_PMUL:
            begin
                cmd.mul_sel = tk_pkg::MUL_PRED;
                state_next  = S_PWR;
            end
            S_PWR:
            begin
                cmd.wr_pred = 1'b1;
                state_next  = S_FINISH;
            end
            S_JMUL:
            begin
                cmd.mul_sel = tk_pkg::MUL_PROJ;
                state_next  = S_JWR;
            end
            S_JWR:
            begin
                cmd.wr_proj = 1'b1;
                state_next  = S_FINISH;
            end
            S_MSTART:
            begin
                cmd.div_gain_start = 1'b1;
                state_next         = S_MGAIN;
            end
            S_MGAIN:
            begin
                if (!status.div_busy)
                begin
                    cmd.wr_k   = 1'b1;
                    state_next = S_MPMUL;
                end
            end
            S_MPMUL:
            begin
                cmd.mul_sel = tk_pkg::MUL_POS;
                state_next  = S_MNPOS;
            end
            S_MNPOS:
            begin
                cmd.wr_npos = 1'b1;
                state_next  = S_MVSTART;
            end
            S_MVSTART:
            begin
                cmd.div_vel_start = 1'b1;
                state_next        = S_MVWAIT;
            end
            S_MVWAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_MWR;
                end
            end
            S_MWR:
            begin
                cmd.wr_meas = 1'b1;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (can_load)
                begin
                    cmd.load_out = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            oproj_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            oproj_reg  <= oproj_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;

endmodule

// ===== hdl/three_axis_kalman_tracker.sv =====
// top level of the three-axis position and velocity tracker
//
//   channel   handshake                payload
//   input     in_valid / in_ready      command, value_*, load_vel_*, ahead_interval
//   output    out_valid / out_ready    out_pos_*, out_vel_*
//   config    cfg_write                cfg_index, cfg_data
//
// load copies the input into the state; predict and project multiply and then write;
// measure runs the bit-serial divider, which forms the gain and then the velocity
// in each axis lane.
// the three axes run side by side; one item is in work at a time, a finished
// result holds the controller until the previous one is taken, and the next
// item is taken while the last result still waits on out_ready.
// reset clears positions and velocities, sets variances to one and loads the
// default noise and step registers.
module three_axis_kalman_tracker #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [31:0] value_x,
    input  logic signed [31:0] value_y,
    input  logic signed [31:0] value_z,
    input  logic signed [31:0] load_vel_x,
    input  logic signed [31:0] load_vel_y,
    input  logic signed [31:0] load_vel_z,
    input  logic signed [31:0] ahead_interval,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_pos_z,
    output logic signed [31:0] out_vel_x,
    output logic signed [31:0] out_vel_y,
    output logic signed [31:0] out_vel_z
);

    localparam logic [30:0] DEF_Q  = 31'(((1 << FRAC_BITS) + 50) / 100);
    localparam logic [30:0] DEF_R  = 31'(1 << FRAC_BITS);
    localparam logic [30:0] DEF_DT = 31'(((1 << FRAC_BITS) + 5) / 10);

    logic [30:0] q_reg, q_next;
    logic [30:0] r_reg, r_next;
    logic [30:0] dt_reg, dt_next;
    logic [30:0] step_len;

    tk_pkg::tk_cmd_t    cmd;
    tk_pkg::tk_status_t st_x, st_y, st_z;
    tk_pkg::tk_status_t status;

    // configuration writes
    always_comb
    begin
        q_next  = q_reg;
        r_next  = r_reg;
        dt_next = dt_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                tk_pkg::CFG_Q_VAR:     q_next  = cfg_data;
                tk_pkg::CFG_R_VAR:     r_next  = cfg_data;
                tk_pkg::CFG_TIME_STEP: dt_next = cfg_data;
                default:               q_next  = q_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg  <= DEF_Q;
            r_reg  <= DEF_R;
            dt_reg <= DEF_DT;
        end
        else
        begin
            q_reg  <= q_next;
            r_reg  <= r_next;
            dt_reg <= dt_next;
        end
    end

    // a zero step acts as the default step
    assign step_len = (dt_reg == '0) ? DEF_DT : dt_reg;

    assign status.div_busy = st_x.div_busy | st_y.div_busy | st_z.div_busy;

    tk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value_in    (value_x),
        .load_vel_in (load_vel_x),
        .ahead_in    (ahead_interval),
        .q_var       (q_reg),
        .r_var       (r_reg),
        .step_len    (step_len),
        .status      (st_x),
        .out_pos     (out_pos_x),
        .out_vel     (out_vel_x)
    );

    tk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value_in    (value_y),
        .load_vel_in (load_vel_y),
        .ahead_in    (ahead_interval),
        .q_var       (q_reg),
        .r_var       (r_reg),
        .step_len    (step_len),
        .status      (st_y),
        .out_pos     (out_pos_y),
        .out_vel     (out_vel_y)
    );

    tk_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value_in    (value_z),
        .load_vel_in (load_vel_z),
        .ahead_in    (ahead_interval),
        .q_var       (q_reg),
        .r_var       (r_reg),
        .step_len    (step_len),
        .status      (st_z),
        .out_pos     (out_pos_z),
        .out_vel     (out_vel_z)
    );

`ifndef SYNTHESIS
    // lane dividers run in lockstep
    assert property (@(posedge clk) disable iff (!rst_n)
        (st_x.div_busy == st_y.div_busy) && (st_y.div_busy == st_z.div_busy))
        else $error("lane dividers out of step");

    // no item is taken while a divide is running
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !status.div_busy)
        else $error("input ready during divide");

    // an accepted item keeps the block busy next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");
`endif

endmodule
